### hw/rtl/pdh_pkg.sv
// pdh_pkg: shared types and constants of the prefix double hash table
// transaction payloads, function and status codes, alu control
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pdh_pkg;

  localparam int unsigned LEN_W     = 12;
  localparam int unsigned WRAP_W    = 64;
  localparam int unsigned MOD_W     = 30;
  localparam int unsigned BASE2_W   = 25;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned MUL_STEPS = WRAP_W / CHUNK_W;
  localparam int unsigned MOD_STEPS = MOD_W;
  localparam int unsigned CNT_W     = 5;

  localparam logic [WRAP_W-1:0]  BASE_WRAP   = 64'd17477417;
  localparam logic [MOD_W-1:0]   MODP        = 30'd1000000007;
  localparam logic [31:0]        MODP_X2     = 32'd2000000014;
  localparam logic [BASE2_W-1:0] BASE2_RESET = 25'd131;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_MAC,
    OP_MODDBL,
    OP_ADD,
    OP_MODADD,
    OP_RSUB,
    OP_MODSUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e              op;
    logic                 mbit;
    logic [CHUNK_W-1:0]   chunk;
  } alu_ctl_t;

  typedef struct packed {
    func_e              func;
    logic [SYM_W-1:0]   symbol;
    logic [LEN_W-1:0]   left;
    logic [LEN_W-1:0]   right;
  } in_item_t;

  typedef struct packed {
    logic [WRAP_W-1:0]  hash_wrap;
    logic [MOD_W-1:0]   hash_mod;
    logic [LEN_W-1:0]   length;
    status_e            status;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/pdh_alu.sv
// pdh_alu: shared arithmetic unit, 64x16 multiply-accumulate, plain add and reverse subtract,
// and modular double-and-add / add / subtract steps modulo 1000000007
// depends on pdh_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdh_alu (
  input  pdh_pkg::alu_ctl_t     ctl_i,
  input  logic [63:0]           acc_i,
  input  logic [63:0]           opa_i,
  output logic [63:0]           res_o
);
  import pdh_pkg::*;

  logic [79:0] prod;
  logic [31:0] dbl;
  logic [30:0] sum31;
  logic [30:0] dif31;

  always_comb begin
    prod  = 80'(opa_i) * 80'(ctl_i.chunk);
    dbl   = {1'b0, acc_i[MOD_W-1:0], 1'b0}
          + (ctl_i.mbit ? 32'(opa_i[MOD_W-1:0]) : 32'd0);
    sum31 = {1'b0, acc_i[MOD_W-1:0]} + {1'b0, opa_i[MOD_W-1:0]};
    dif31 = {1'b0, opa_i[MOD_W-1:0]} - {1'b0, acc_i[MOD_W-1:0]};
    res_o = acc_i;
    case (ctl_i.op)
      OP_PASS:   res_o = acc_i;
      OP_MAC:    res_o = acc_i + prod[63:0];
      OP_MODDBL: begin
        // operands below p, so one of two corrections lands it in range
        if (dbl >= MODP_X2) begin
          res_o = 64'(dbl - MODP_X2);
        end else if (dbl >= 32'(MODP)) begin
          res_o = 64'(dbl - 32'(MODP));
        end else begin
          res_o = 64'(dbl);
        end
      end
      OP_ADD:    res_o = acc_i + opa_i;
      OP_MODADD: begin
        if (sum31 >= 31'(MODP)) begin
          res_o = 64'(sum31 - 31'(MODP));
        end else begin
          res_o = 64'(sum31);
        end
      end
      OP_RSUB:   res_o = opa_i - acc_i;
      OP_MODSUB: begin
        if (opa_i[MOD_W-1:0] >= acc_i[MOD_W-1:0]) begin
          res_o = 64'(dif31);
        end else begin
          res_o = 64'(dif31 + 31'(MODP));
        end
      end
      default:   res_o = acc_i;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/pdh_ram.sv
// pdh_ram: simple dual-port memory, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pdh_ram #(
  parameter int unsigned WIDTH = 94,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/prefix_double_hash_table.sv
// append and query read the tables and run their alu products before the result is built;
// a whole-string read skips the products; clear, table full and bad range answer from idle
// one transaction at a time, ready again in the cycle after the result is taken;
// the shared alu runs 4 multiply-accumulate steps per 64-bit product
// and 30 double-and-add steps per modular product, one step per cycle
// reset: string empty, base2 = 131, no clearing pass; uses pdh_pkg, pdh_alu, pdh_ram
`timescale 1ns / 1ps
`default_nettype none

module prefix_double_hash_table #(
  parameter int unsigned MAX_LEN = 4095
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pdh_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pdh_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [24:0]         cfg_data_i
);
  import pdh_pkg::*;

  localparam int unsigned DEPTH = MAX_LEN + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (AW > LEN_W) ? AW : LEN_W;
  localparam int unsigned RW    = WRAP_W + MOD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD2, S_LOAD, S_SETUP, S_MUL, S_POST, S_WR, S_OUT
  } state_e;

  state_e              state_q;
  in_item_t            item_q;
  logic [AW-1:0]       len_q;
  logic [BASE2_W-1:0]  base2_q;
  logic [WRAP_W-1:0]   w0_q, w1_q, w2_q;
  logic [MOD_W-1:0]    m0_q, m1_q, m2_q;
  logic [63:0]         acc_q, a_q, b_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [1:0]          job_q;
  logic                zp_q, zf_q;
  out_item_t           out_q;
  logic                out_valid_q;

  logic [AW-1:0]       pow_raddr, pre_raddr, len_inc;
  logic [RW-1:0]       pow_rdata, pre_rdata;
  logic [WRAP_W-1:0]   pow_w, pre_w;
  logic [MOD_W-1:0]    pow_m, pre_m;
  logic                mem_we;
  logic [LEN_W-1:0]    d_in;
  logic                is_app;
  logic                job_mod, job_last;
  logic [63:0]         job_a, job_b, job_pa;
  alu_op_e             job_post;
  alu_ctl_t            alu_ctl;
  logic [63:0]         alu_opa, alu_res;
  logic                bad_range;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign len_inc     = len_q + AW'(1);
  assign d_in        = in_data_i.right - in_data_i.left;
  assign is_app      = (item_q.func == FUNC_APPEND);
  assign bad_range   = (in_data_i.left > in_data_i.right)
                     || (CW'(in_data_i.right) > CW'(len_q));

  // read addresses: for a query, first pass from the incoming item, second from the held one; else the length
  always_comb begin
    pow_raddr = len_q;
    pre_raddr = len_q;
    if (state_q == S_IDLE && in_data_i.func == FUNC_QUERY) begin
      pow_raddr = AW'(d_in);
      pre_raddr = AW'(in_data_i.right);
    end else if (state_q == S_RD2 && item_q.func == FUNC_QUERY) begin
      pre_raddr = AW'(item_q.left);
    end
  end

  // entry zero reads as its reset value
  assign pow_w = zp_q ? WRAP_W'(1) : pow_rdata[RW-1:MOD_W];
  assign pow_m = zp_q ? MOD_W'(1)  : pow_rdata[MOD_W-1:0];
  assign pre_w = zf_q ? '0 : pre_rdata[RW-1:MOD_W];
  assign pre_m = zf_q ? '0 : pre_rdata[MOD_W-1:0];

  assign mem_we = (state_q == S_WR) && is_app;

  pdh_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_pow_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_inc),
    .wdata_i ({w0_q, m0_q}),
    .raddr_i (pow_raddr),
    .rdata_o (pow_rdata)
  );

  pdh_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_pre_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_inc),
    .wdata_i ({w1_q, m1_q}),
    .raddr_i (pre_raddr),
    .rdata_o (pre_rdata)
  );

  // job table: append runs four products, query two
  always_comb begin
    job_mod  = 1'b0;
    job_last = 1'b0;
    job_a    = w1_q;
    job_b    = w0_q;
    job_pa   = '0;
    job_post = OP_PASS;
    if (is_app) begin
      job_mod  = job_q[1];
      job_last = (job_q == 2'd3);
      job_b    = job_q[1] ? 64'(base2_q) : BASE_WRAP;
      case (job_q)
        2'd0: job_a = w0_q;
        2'd1: begin
          job_a    = w1_q;
          job_post = OP_ADD;
          job_pa   = 64'(item_q.symbol);
        end
        2'd2: job_a = 64'(m0_q);
        2'd3: begin
          job_a    = 64'(m1_q);
          job_post = OP_MODADD;
          job_pa   = 64'(item_q.symbol);
        end
        default: job_a = w0_q;
      endcase
    end else begin
      job_mod  = job_q[0];
      job_last = job_q[0];
      if (job_q[0]) begin
        job_a    = 64'(m1_q);
        job_b    = 64'(m0_q);
        job_post = OP_MODSUB;
        job_pa   = 64'(m2_q);
      end else begin
        job_post = OP_RSUB;
        job_pa   = w2_q;
      end
    end
  end

  always_comb begin
    alu_ctl.op    = (state_q == S_POST) ? job_post : (job_mod ? OP_MODDBL : OP_MAC);
    alu_ctl.mbit  = b_q[MOD_W-1];
    alu_ctl.chunk = b_q[CHUNK_W-1:0];
    alu_opa       = (state_q == S_POST) ? job_pa : a_q;
  end

  pdh_alu u_alu (
    .ctl_i (alu_ctl),
    .acc_i (acc_q),
    .opa_i (alu_opa),
    .res_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      base2_q     <= BASE2_RESET;
      out_valid_q <= 1'b0;
      job_q       <= '0;
      cnt_q       <= '0;
      zp_q        <= 1'b0;
      zf_q        <= 1'b0;
    end else begin
      zp_q <= (pow_raddr == '0);
      zf_q <= (pre_raddr == '0);
      if (cfg_valid_i) begin
        base2_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            case (in_data_i.func)
              FUNC_APPEND: begin
                if (CW'(len_q) == CW'(MAX_LEN)) begin
                  out_q       <= '{hash_wrap: '0, hash_mod: '0,
                                   length: LEN_W'(len_q), status: ST_FULL};
                  out_valid_q <= 1'b1;
                  state_q     <= S_OUT;
                end else begin
                  state_q <= S_RD2;
                end
              end
              FUNC_QUERY: begin
                if (bad_range) begin
                  out_q       <= '{hash_wrap: '0, hash_mod: '0,
                                   length: LEN_W'(len_q), status: ST_BAD_RANGE};
                  out_valid_q <= 1'b1;
                  state_q     <= S_OUT;
                end else begin
                  state_q <= S_RD2;
                end
              end
              FUNC_CLEAR: begin
                len_q       <= '0;
                out_q       <= '{hash_wrap: '0, hash_mod: '0,
                                 length: '0, status: ST_OK};
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end
              default: state_q <= S_RD2;
            endcase
          end
        end
        S_RD2: begin
          w0_q    <= pow_w;
          m0_q    <= pow_m;
          w2_q    <= pre_w;
          m2_q    <= pre_m;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          w1_q    <= pre_w;
          m1_q    <= pre_m;
          job_q   <= '0;
          state_q <= (item_q.func == FUNC_READ) ? S_WR : S_SETUP;
        end
        S_SETUP: begin
          acc_q   <= '0;
          a_q     <= job_a;
          b_q     <= job_b;
          cnt_q   <= job_mod ? CNT_W'(MOD_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
          state_q <= S_MUL;
        end
        S_MUL: begin
          acc_q <= alu_res;
          if (job_mod) begin
            b_q <= b_q << 1;
          end else begin
            a_q <= a_q << CHUNK_W;
            b_q <= b_q >> CHUNK_W;
          end
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (job_mod) begin
            if (is_app && !job_q[0]) begin
              m0_q <= alu_res[MOD_W-1:0];
            end else begin
              m1_q <= alu_res[MOD_W-1:0];
            end
          end else begin
            if (is_app && job_q == 2'd0) begin
              w0_q <= alu_res;
            end else begin
              w1_q <= alu_res;
            end
          end
          job_q   <= job_q + 2'd1;
          state_q <= job_last ? S_WR : S_SETUP;
        end
        S_WR: begin
          if (is_app) begin
            len_q <= len_inc;
          end
          out_q       <= '{hash_wrap: w1_q, hash_mod: m1_q,
                           length: LEN_W'(is_app ? len_inc : len_q), status: ST_OK};
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pdh_checker.sv
// pdh_checker: port-level assertions for prefix_double_hash_table
// bound to the top level below; depends on pdh_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdh_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pdh_pkg::out_item_t  out_data_o
);
  import pdh_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // one transaction in flight: no new item while a result waits
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result waits");

  // an accepted transaction keeps the input closed for at least the next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready again right after accept");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.hash_wrap == '0 && out_data_o.hash_mod == '0)
    else $error("error status with nonzero hash");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hash_mod < MODP)
    else $error("second hash out of range");

endmodule

bind prefix_double_hash_table pdh_checker u_pdh_checker (.*);

`default_nettype wire

### test/prefix_double_hash_table_test.sv
// prefix_double_hash_table_test: self-checking bench for the prefix double hash table
// predicts appends, range queries, whole-string reads, clears and errors with base2 changes between phases
// depends on pdh_pkg and the prefix_double_hash_table rtl
`timescale 1ns / 1ps

module prefix_double_hash_table_test;
  import pdh_pkg::*;

  localparam int unsigned TEXT_MAX = 4095;
  localparam longint unsigned WRAP_BASE = 64'd17477417;
  localparam longint unsigned PRIME = 64'd1000000007;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [24:0] cfg_data_i = '0;

  prefix_double_hash_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state
  longint unsigned pow_w [TEXT_MAX+1];
  longint unsigned pow_m [TEXT_MAX+1];
  longint unsigned pre_w [TEXT_MAX+1];
  longint unsigned pre_m [TEXT_MAX+1];
  int unsigned     text_len;
  longint unsigned hash_base2;

  out_item_t pending_hashes[$];
  int unsigned hash_errors = 0;
  int unsigned burst_left = 0;
  bit hold_req = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("prefix_double_hash_table regression: fail");
    $finish;
  end

  function automatic in_item_t mk(func_e f, int unsigned sym, int unsigned l, int unsigned r);
    in_item_t it;
    it.func   = f;
    it.symbol = sym[7:0];
    it.left   = l[11:0];
    it.right  = r[11:0];
    return it;
  endfunction

  function automatic out_item_t mkx(longint unsigned hw, longint unsigned hm,
                                    int unsigned len, status_e st);
    out_item_t o;
    o.hash_wrap = hw;
    o.hash_mod  = hm[29:0];
    o.length    = len[11:0];
    o.status    = st;
    return o;
  endfunction

  function automatic out_item_t hash_step(in_item_t it);
    out_item_t o;
    int unsigned i, d, l, r;
    longint unsigned hm;
    o = '0;
    o.status = ST_OK;
    l = it.left;
    r = it.right;
    case (it.func)
      FUNC_APPEND: begin
        if (text_len >= TEXT_MAX) begin
          o.status = ST_FULL;
        end else begin
          i = text_len + 1;
          pow_w[i] = pow_w[i-1] * WRAP_BASE;
          pow_m[i] = (pow_m[i-1] * hash_base2) % PRIME;
          pre_w[i] = pre_w[i-1] * WRAP_BASE + longint'(it.symbol);
          pre_m[i] = (pre_m[i-1] * hash_base2 + longint'(it.symbol)) % PRIME;
          text_len = i;
          o.hash_wrap = pre_w[i];
          o.hash_mod  = pre_m[i][29:0];
        end
      end
      FUNC_QUERY: begin
        if (l > r || r > text_len) begin
          o.status = ST_BAD_RANGE;
        end else begin
          d = r - l;
          o.hash_wrap = pre_w[r] - pre_w[l] * pow_w[d];
          hm = (pre_m[r] + PRIME - (pre_m[l] * pow_m[d]) % PRIME) % PRIME;
          o.hash_mod  = hm[29:0];
        end
      end
      FUNC_CLEAR: text_len = 0;
      default: begin
        o.hash_wrap = pre_w[text_len];
        o.hash_mod  = pre_m[text_len][29:0];
      end
    endcase
    o.length = text_len[11:0];
    return o;
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (pending_hashes.size() == 0) begin
      hash_errors++;
      if (hash_errors <= 10)
        $display("unexpected result %h", got);
      return;
    end
    want = pending_hashes.pop_front();
    if (got.hash_wrap !== want.hash_wrap || got.hash_mod !== want.hash_mod ||
        got.length !== want.length || got.status !== want.status) begin
      hash_errors++;
      if (hash_errors <= 10)
        $display("mismatch: exp wrap %h mod %0d len %0d st %0d, got wrap %h mod %0d len %0d st %0d",
                 want.hash_wrap, want.hash_mod, want.length, want.status,
                 got.hash_wrap, got.hash_mod, got.length, got.status);
    end
  endfunction

  // receiver with its own stall pattern and one long hold-off
  initial begin
    int unsigned pct, cyc, hold_left;
    pct = 0;
    cyc = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(2))
          0: pct = 0;
          1: pct = 30;
          default: pct = 75;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= pct);
      end
    end
  end

  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) begin
      void'(hash_step(it));
      pending_hashes.push_back(want);
    end else begin
      pending_hashes.push_back(hash_step(it));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_hashes.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base2(int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[24:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    hash_base2 = value & 32'h1FF_FFFF;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t random_item();
    int unsigned pick, l, r;
    pick = $urandom_range(99);
    if (pick < 45)
      return mk(FUNC_APPEND, $urandom, $urandom, $urandom);
    if (pick < 80) begin
      r = $urandom_range(text_len, 0);
      l = $urandom_range(r, 0);
      return mk(FUNC_QUERY, $urandom, l, r);
    end
    if (pick < 88) begin
      if (text_len < TEXT_MAX && $urandom_range(1))
        return mk(FUNC_QUERY, $urandom, $urandom_range(4095), $urandom_range(4095, text_len + 1));
      r = $urandom_range(4094);
      return mk(FUNC_QUERY, $urandom, $urandom_range(4095, r + 1), r);
    end
    if (pick < 94)
      return mk(FUNC_CLEAR, $urandom, $urandom, $urandom);
    return mk(FUNC_READ, $urandom, $urandom, $urandom);
  endfunction

  initial begin
    stim_row_t rows[$];
    hash_base2 = 131;
    text_len = 0;
    pow_w[0] = 1;
    pow_m[0] = 1;
    pre_w[0] = 0;
    pre_m[0] = 0;

    rows = '{
      '{mk(FUNC_QUERY, 0, 0, 0), 1, mkx(0, 0, 0, ST_OK)},
      '{mk(FUNC_QUERY, 0, 1, 0), 1, mkx(0, 0, 0, ST_BAD_RANGE)},
      '{mk(FUNC_QUERY, 0, 0, 1), 1, mkx(0, 0, 0, ST_BAD_RANGE)},
      '{mk(FUNC_READ, 0, 0, 0), 1, mkx(0, 0, 0, ST_OK)},
      '{mk(FUNC_APPEND, 0, 0, 0), 1, mkx(0, 0, 1, ST_OK)},
      '{mk(FUNC_APPEND, 255, 4095, 4095), 1, mkx(255, 255, 2, ST_OK)},
      '{mk(FUNC_APPEND, 1, 0, 0), 0, '0},
      '{mk(FUNC_QUERY, 0, 0, 3), 0, '0},
      '{mk(FUNC_QUERY, 0, 1, 3), 0, '0},
      '{mk(FUNC_QUERY, 255, 2, 2), 1, mkx(0, 0, 3, ST_OK)},
      '{mk(FUNC_QUERY, 0, 3, 3), 1, mkx(0, 0, 3, ST_OK)},
      '{mk(FUNC_QUERY, 0, 0, 4), 1, mkx(0, 0, 3, ST_BAD_RANGE)},
      '{mk(FUNC_QUERY, 0, 4095, 4095), 1, mkx(0, 0, 3, ST_BAD_RANGE)},
      '{mk(FUNC_READ, 255, 4095, 0), 0, '0},
      '{mk(FUNC_APPEND, 128, 0, 0), 0, '0},
      '{mk(FUNC_APPEND, 127, 0, 0), 0, '0},
      '{mk(FUNC_QUERY, 0, 0, 5), 0, '0},
      '{mk(FUNC_QUERY, 0, 4, 3), 1, mkx(0, 0, 5, ST_BAD_RANGE)},
      '{mk(FUNC_CLEAR, 255, 4095, 4095), 1, mkx(0, 0, 0, ST_OK)},
      '{mk(FUNC_QUERY, 0, 0, 0), 1, mkx(0, 0, 0, ST_OK)},
      '{mk(FUNC_READ, 0, 0, 0), 1, mkx(0, 0, 0, ST_OK)},
      '{mk(FUNC_QUERY, 0, 0, 4095), 1, mkx(0, 0, 0, ST_BAD_RANGE)},
      '{mk(FUNC_APPEND, 255, 0, 0), 1, mkx(255, 255, 1, ST_OK)}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of base2 is used by the directed rows
    foreach (rows[k]) send(rows[k].item, rows[k].typed, rows[k].want);
    drain();

    write_base2(20240457);
    repeat (250) send(random_item());
    drain();

    write_base2($urandom_range(20240457, 131));
    for (int n = 0; n < 250; n++) begin
      if (n == 100) hold_req = 1'b1;
      send(random_item());
    end
    drain();

    // grow the string, base changes midway
    write_base2(131);
    send(mk(FUNC_CLEAR, 0, 0, 0));
    while (text_len < 250) begin
      if ($urandom_range(9) == 0) send(random_item());
      else send(mk(FUNC_APPEND, $urandom, $urandom, $urandom));
      if (text_len == 0) send(mk(FUNC_APPEND, $urandom, 0, 0));
    end
    drain();
    write_base2(20240327);
    while (text_len < 500) begin
      if ($urandom_range(9) == 0)
        send(mk(FUNC_QUERY, $urandom, $urandom_range(text_len, 0), text_len));
      else
        send(mk(FUNC_APPEND, $urandom, $urandom, $urandom));
    end
    send(mk(FUNC_QUERY, 0, 0, text_len));
    send(mk(FUNC_QUERY, 0, 0, 4095));
    send(mk(FUNC_QUERY, 0, 4095, 4095));
    send(mk(FUNC_QUERY, 0, text_len, text_len));
    send(mk(FUNC_READ, 0, 0, 0));
    repeat (20) send(random_item());
    drain();

    write_base2($urandom_range(20240457, 131));
    repeat (250) send(random_item());
    drain();

    repeat (100) @(posedge clk_i);
    if (hash_errors == 0 && pending_hashes.size() == 0) begin
      $display("prefix_double_hash_table regression: pass");
    end else begin
      $display("prefix_double_hash_table regression: fail");
    end
    $finish;
  end

endmodule

### prefix_double_hash_table.f
hw/rtl/pdh_pkg.sv
hw/rtl/pdh_alu.sv
hw/rtl/pdh_ram.sv
hw/rtl/prefix_double_hash_table.sv
hw/rtl/pdh_checker.sv
test/prefix_double_hash_table_test.sv
